// ----- hw/rtl/st_pkg.sv -----
package st_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef enum logic [4:0] {
        K_NEWLINE = 5'd0,
        K_END     = 5'd1,
        K_PLUS    = 5'd2,
        K_MINUS   = 5'd3,
        K_SLASH   = 5'd4,
        K_STAR    = 5'd5,
        K_LPAREN  = 5'd6,
        K_RPAREN  = 5'd7,
        K_EQ      = 5'd8,
        K_EQEQ    = 5'd9,
        K_NOTEQ   = 5'd10,
        K_GT      = 5'd11,
        K_GTEQ    = 5'd12,
        K_LT      = 5'd13,
        K_LTEQ    = 5'd14,
        K_STRING  = 5'd15,
        K_NUMBER  = 5'd16,
        K_IDENT   = 5'd17,
        K_ERROR   = 5'd18
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_BANG     = 3'd1,
        E_UNCLOSED = 3'd2,
        E_FRACTION = 3'd3,
        E_UNKNOWN  = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_OP      = 4'd2,
        M_STRING  = 4'd3,
        M_INT     = 4'd4,
        M_DOT     = 4'd5,
        M_FRAC    = 4'd6,
        M_IDENT   = 4'd7
    } t_mode;

    typedef enum logic [1:0] {
        P_EQ   = 2'd0,
        P_BANG = 2'd1,
        P_GT   = 2'd2,
        P_LT   = 2'd3
    } t_pend;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        t_kind       token_kind;
        logic [15:0] start_offset;
        logic [15:0] text_length;
        t_err        error_code;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0] cnt;
        t_out [MAX_RESULTS-1:0] res;
    } t_bundle;

    typedef struct packed {
        logic  emit;
        t_kind kind;
        t_err  err;
        logic  halt;
        t_mode mode;
        logic  set_start;
        logic  skip_quote;
    } t_idle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic t_kind op_single(input t_pend p);
        t_kind k;
        unique case (p)
            P_EQ:    k = K_EQ;
            P_BANG:  k = K_NEWLINE;
            P_GT:    k = K_GT;
            default: k = K_LT;
        endcase
        return k;
    endfunction

    function automatic t_kind op_double(input t_pend p);
        t_kind k;
        unique case (p)
            P_EQ:    k = K_EQEQ;
            P_BANG:  k = K_NOTEQ;
            P_GT:    k = K_GTEQ;
            default: k = K_LTEQ;
        endcase
        return k;
    endfunction

    function automatic t_pend pend_of(input logic [7:0] c);
        t_pend p;
        if (c == CH_EQ) begin
            p = P_EQ;
        end else if (c == CH_BANG) begin
            p = P_BANG;
        end else if (c == CH_GT) begin
            p = P_GT;
        end else begin
            p = P_LT;
        end
        return p;
    endfunction

    // scan of one byte between tokens
    function automatic t_idle idle_scan(input logic [7:0] c);
        t_idle r;
        r = '{emit: 1'b0, kind: K_NEWLINE, err: E_NONE, halt: 1'b0, mode: M_IDLE,
              set_start: 1'b0, skip_quote: 1'b0};
        unique case (c)
            CH_SP, CH_TAB, CH_CR: r.emit = 1'b0;
            CH_HASH:  r.mode = M_COMMENT;
            CH_NL:    begin r.emit = 1'b1; r.kind = K_NEWLINE; end
            CH_PLUS:  begin r.emit = 1'b1; r.kind = K_PLUS; end
            CH_MINUS: begin r.emit = 1'b1; r.kind = K_MINUS; end
            CH_SLASH: begin r.emit = 1'b1; r.kind = K_SLASH; end
            CH_STAR:  begin r.emit = 1'b1; r.kind = K_STAR; end
            CH_LP:    begin r.emit = 1'b1; r.kind = K_LPAREN; end
            CH_RP:    begin r.emit = 1'b1; r.kind = K_RPAREN; end
            CH_EQ, CH_BANG, CH_GT, CH_LT: begin
                r.mode = M_OP;
                r.set_start = 1'b1;
            end
            CH_QUOTE: begin
                r.mode = M_STRING;
                r.set_start = 1'b1;
                r.skip_quote = 1'b1;
            end
            default: begin
                if (is_digit(c)) begin
                    r.mode = M_INT;
                    r.set_start = 1'b1;
                end else if (is_letter(c)) begin
                    r.mode = M_IDENT;
                    r.set_start = 1'b1;
                end else begin
                    r.emit = 1'b1;
                    r.kind = K_ERROR;
                    r.err  = E_UNKNOWN;
                    r.halt = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/source_tokenizer.sv -----
// Streaming tokenizer for line-oriented source text.
// Input channel: one transfer per source byte (command 0) or an end-of-source
// command (command 1). Output channel: one transfer per token with kind, start
// offset, length, error code and a flag on the last token a transfer caused.
// Throughput: one input transfer per cycle while the output keeps up; the
// output side moves one token per cycle, so a byte that yields two or three
// tokens keeps the output busy with each of them in turn.
// A byte's tokens are written into the queue as a bundle when the byte is
// transferred in, and appear on the output once earlier bundles have drained.
// The scanner front end updates its state each byte and pushes the tokens of
// that byte as one bundle into a four-entry queue; the back end drains bundles
// token by token. When the receiver stalls the queue fills and input ready drops.
// After an error token the block ignores further input until reset.
// An end-of-source transfer that does not end in an error returns the scanner to its reset state.
// Reset (synchronous, active low) empties the queue and clears the scan state.
module source_tokenizer #(
    parameter int OFFSET_BITS = st_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = st_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  st_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output st_pkg::t_out o_out_data
);

    logic            push, pop, full, empty;
    st_pkg::t_bundle push_data, head;

    assign o_in_ready = !full;

    st_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && o_in_ready),
        .i_data   (i_in_data),
        .o_push   (push),
        .o_bundle (push_data)
    );

    st_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    st_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ----- hw/rtl/st_front.sv -----
module st_front #(
    parameter int OFFSET_BITS = st_pkg::OFFSET_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  st_pkg::t_in     i_data,
    output logic            o_push,
    output st_pkg::t_bundle o_bundle
);

    localparam int OW = OFFSET_BITS;

    function automatic logic [15:0] fit16(input logic [OW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    st_pkg::t_mode   r_mode, n_mode;
    logic [OW-1:0]   r_tstart, n_tstart;
    logic [OW-1:0]   r_off, n_off;
    st_pkg::t_pend   r_pend, n_pend;
    logic            r_halt, n_halt;

    logic [7:0]      c;
    logic            live;
    st_pkg::t_idle   idl;

    assign c    = i_data.command ? st_pkg::CH_NL : i_data.char_code;
    assign live = i_accept && !r_halt;
    assign idl  = st_pkg::idle_scan(c);

    // next state
    always_comb begin
        logic use_idle;
        use_idle = 1'b0;
        n_mode   = r_mode;
        n_tstart = r_tstart;
        n_off    = r_off;
        n_pend   = r_pend;
        n_halt   = r_halt;
        if (live) begin
            unique case (r_mode)
                st_pkg::M_COMMENT: begin
                    if (c == st_pkg::CH_NL) n_mode = st_pkg::M_IDLE;
                end
                st_pkg::M_OP: begin
                    n_mode = st_pkg::M_IDLE;
                    if (c != st_pkg::CH_EQ) begin
                        if (r_pend == st_pkg::P_BANG) n_halt = 1'b1;
                        else use_idle = 1'b1;
                    end
                end
                st_pkg::M_STRING: begin
                    if (c == st_pkg::CH_QUOTE) begin
                        n_mode = st_pkg::M_IDLE;
                    end else if (c == st_pkg::CH_NL) begin
                        n_mode = st_pkg::M_IDLE;
                        n_halt = 1'b1;
                    end
                end
                st_pkg::M_INT: begin
                    if (c == st_pkg::CH_DOT) n_mode = st_pkg::M_DOT;
                    else if (!st_pkg::is_digit(c)) use_idle = 1'b1;
                end
                st_pkg::M_DOT: begin
                    if (st_pkg::is_digit(c)) begin
                        n_mode = st_pkg::M_FRAC;
                    end else begin
                        n_mode = st_pkg::M_IDLE;
                        n_halt = 1'b1;
                    end
                end
                st_pkg::M_FRAC: begin
                    if (!st_pkg::is_digit(c)) use_idle = 1'b1;
                end
                st_pkg::M_IDENT: begin
                    if (!(st_pkg::is_letter(c) || st_pkg::is_digit(c) ||
                          c == st_pkg::CH_UNDER)) use_idle = 1'b1;
                end
                default: use_idle = 1'b1;
            endcase
            if (use_idle) begin
                n_mode = idl.mode;
                if (idl.set_start) n_tstart = r_off + OW'(idl.skip_quote);
                if (idl.mode == st_pkg::M_OP) n_pend = st_pkg::pend_of(c);
                if (idl.halt) n_halt = 1'b1;
            end
            if (i_data.command) begin
                if (!n_halt) begin
                    n_mode   = st_pkg::M_IDLE;
                    n_tstart = '0;
                    n_pend   = st_pkg::P_EQ;
                    n_off    = '0;
                end
            end else begin
                n_off = r_off + OW'(1);
            end
        end
    end

    // results
    always_comb begin
        st_pkg::t_out a, b, e;
        logic         a_v, b_v, e_v, use_idle;
        logic [1:0]   cnt;
        a = '{token_kind: st_pkg::K_NEWLINE, start_offset: fit16(r_off), text_length: 16'd1,
              error_code: st_pkg::E_NONE, last_of_run: 1'b0};
        a_v      = 1'b0;
        use_idle = 1'b0;
        unique case (r_mode)
            st_pkg::M_COMMENT: a_v = (c == st_pkg::CH_NL);
            st_pkg::M_OP: begin
                a_v = 1'b1;
                if (c == st_pkg::CH_EQ) begin
                    a.token_kind   = st_pkg::op_double(r_pend);
                    a.start_offset = fit16(r_tstart);
                    a.text_length  = 16'd2;
                end else if (r_pend == st_pkg::P_BANG) begin
                    a.token_kind  = st_pkg::K_ERROR;
                    a.text_length = 16'd0;
                    a.error_code  = st_pkg::E_BANG;
                end else begin
                    a.token_kind   = st_pkg::op_single(r_pend);
                    a.start_offset = fit16(r_tstart);
                    use_idle       = 1'b1;
                end
            end
            st_pkg::M_STRING: begin
                if (c == st_pkg::CH_QUOTE) begin
                    a_v            = 1'b1;
                    a.token_kind   = st_pkg::K_STRING;
                    a.start_offset = fit16(r_tstart);
                    a.text_length  = fit16(r_off - r_tstart);
                end else if (c == st_pkg::CH_NL) begin
                    a_v           = 1'b1;
                    a.token_kind  = st_pkg::K_ERROR;
                    a.text_length = 16'd0;
                    a.error_code  = st_pkg::E_UNCLOSED;
                end
            end
            st_pkg::M_INT, st_pkg::M_FRAC: begin
                if (!st_pkg::is_digit(c) &&
                    !(r_mode == st_pkg::M_INT && c == st_pkg::CH_DOT)) begin
                    a_v            = 1'b1;
                    a.token_kind   = st_pkg::K_NUMBER;
                    a.start_offset = fit16(r_tstart);
                    a.text_length  = fit16(r_off - r_tstart);
                    use_idle       = 1'b1;
                end
            end
            st_pkg::M_DOT: begin
                if (!st_pkg::is_digit(c)) begin
                    a_v           = 1'b1;
                    a.token_kind  = st_pkg::K_ERROR;
                    a.text_length = 16'd0;
                    a.error_code  = st_pkg::E_FRACTION;
                end
            end
            st_pkg::M_IDENT: begin
                if (!(st_pkg::is_letter(c) || st_pkg::is_digit(c) ||
                      c == st_pkg::CH_UNDER)) begin
                    a_v            = 1'b1;
                    a.token_kind   = st_pkg::K_IDENT;
                    a.start_offset = fit16(r_tstart);
                    a.text_length  = fit16(r_off - r_tstart);
                    use_idle       = 1'b1;
                end
            end
            default: use_idle = 1'b1;
        endcase

        b_v = use_idle && idl.emit;
        b   = '{token_kind: idl.kind, start_offset: fit16(r_off),
                text_length: idl.halt ? 16'd0 : 16'd1, error_code: idl.err,
                last_of_run: 1'b0};

        e_v = i_data.command &&
              !(a_v && a.token_kind == st_pkg::K_ERROR) &&
              !(b_v && b.token_kind == st_pkg::K_ERROR);
        e   = '{token_kind: st_pkg::K_END, start_offset: fit16(r_off + OW'(1)),
                text_length: 16'd0, error_code: st_pkg::E_NONE, last_of_run: 1'b0};

        o_bundle = '0;
        cnt      = 2'd0;
        if (a_v) begin
            o_bundle.res[cnt] = a;
            cnt = cnt + 2'd1;
        end
        if (b_v) begin
            o_bundle.res[cnt] = b;
            cnt = cnt + 2'd1;
        end
        if (e_v) begin
            o_bundle.res[cnt] = e;
            cnt = cnt + 2'd1;
        end
        if (cnt != 2'd0) o_bundle.res[cnt - 2'd1].last_of_run = 1'b1;
        o_bundle.cnt = cnt;
        o_push       = live && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= st_pkg::M_IDLE;
            r_tstart <= '0;
            r_off    <= '0;
            r_pend   <= st_pkg::P_EQ;
            r_halt   <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_tstart <= n_tstart;
            r_off    <= n_off;
            r_pend   <= n_pend;
            r_halt   <= n_halt;
        end
    end

endmodule

// ----- hw/rtl/st_queue.sv -----
module st_queue #(
    parameter int DEPTH = st_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  st_pkg::t_bundle i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output st_pkg::t_bundle o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    st_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop) r_rd <= bump(r_rd);
            if (i_push && !i_pop) r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ----- hw/rtl/st_back.sv -----
module st_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  st_pkg::t_bundle i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output st_pkg::t_out    o_data
);

    logic [1:0] r_idx, n_idx;
    logic       xfer;

    assign o_valid = !i_empty;
    assign o_data  = i_head.res[r_idx];
    assign xfer    = o_valid && i_ready;
    assign o_pop   = xfer && (r_idx == i_head.cnt - 2'd1);

    always_comb begin
        n_idx = r_idx;
        if (o_pop) n_idx = 2'd0;
        else if (xfer) n_idx = r_idx + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= 2'd0;
        else r_idx <= n_idx;
    end

endmodule

// ----- hw/rtl/st_checker.sv -----
module st_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input st_pkg::t_out o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_kind == st_pkg::K_ERROR) |->
        (o_out_data.last_of_run && o_out_data.text_length == 16'd0 &&
         o_out_data.error_code != st_pkg::E_NONE))
        else $error("malformed error token");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_kind == st_pkg::K_END) |->
        (o_out_data.last_of_run && o_out_data.text_length == 16'd0))
        else $error("malformed end token");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_kind != st_pkg::K_ERROR) |->
        (o_out_data.error_code == st_pkg::E_NONE))
        else $error("error code on a normal token");

endmodule

bind source_tokenizer st_checker u_st_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/sv/tb_source_tokenizer.sv -----
`timescale 1ns / 100ps

module tb_source_tokenizer;

    localparam logic        CMD_BYTE    = 1'b0;
    localparam logic        CMD_END     = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 100000;

    typedef struct {
        st_pkg::t_in  item;
        bit           typed;
        st_pkg::t_out want;
    } t_row;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    st_pkg::t_in  in_data;
    logic         out_valid;
    logic         out_ready;
    st_pkg::t_out out_data;

    // scanner shadow state
    st_pkg::t_mode sc_mode;
    logic [15:0]   sc_start;
    logic [15:0]   sc_off;
    st_pkg::t_pend sc_pend;
    logic          sc_halted;

    st_pkg::t_out step_tokens[$];
    st_pkg::t_out expected_tokens[$];
    t_row         directed_rows[$];
    st_pkg::t_in  source_bytes[$];

    int          n_sent;
    int          mismatches;
    int unsigned cycle_count;
    logic        hold_off;
    logic        calm;
    bit          prev_word;

    assign calm = (n_sent >= 60) && (n_sent < 110);

    source_tokenizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------- token predictor ----------------

    function automatic bit dec_digit(logic [7:0] c);
        return c inside {[st_pkg::CH_0:st_pkg::CH_9]};
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c inside {[st_pkg::CH_UA:st_pkg::CH_UZ]}) ||
               (c inside {[st_pkg::CH_LA:st_pkg::CH_LZ]});
    endfunction

    function automatic void push_token(st_pkg::t_kind kind, logic [15:0] start,
                                       logic [15:0] len, st_pkg::t_err err);
        st_pkg::t_out tok;
        if (step_tokens.size() < st_pkg::MAX_RESULTS) begin
            tok.token_kind   = kind;
            tok.start_offset = start;
            tok.text_length  = len;
            tok.error_code   = err;
            tok.last_of_run  = 1'b0;
            step_tokens.push_back(tok);
        end
    endfunction

    function automatic void halt_on(st_pkg::t_err err, logic [15:0] off);
        push_token(st_pkg::K_ERROR, off, 16'd0, err);
        sc_halted = 1'b1;
        sc_mode   = st_pkg::M_IDLE;
    endfunction

    function automatic void close_token(st_pkg::t_kind kind, logic [15:0] off);
        push_token(kind, sc_start, off - sc_start, st_pkg::E_NONE);
        sc_mode = st_pkg::M_IDLE;
    endfunction

    function automatic void scan_idle(logic [7:0] c, logic [15:0] off);
        case (c)
            st_pkg::CH_SP, st_pkg::CH_TAB, st_pkg::CH_CR: begin
            end
            st_pkg::CH_HASH:  sc_mode = st_pkg::M_COMMENT;
            st_pkg::CH_NL:    push_token(st_pkg::K_NEWLINE, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_PLUS:  push_token(st_pkg::K_PLUS, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_MINUS: push_token(st_pkg::K_MINUS, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_SLASH: push_token(st_pkg::K_SLASH, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_STAR:  push_token(st_pkg::K_STAR, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_LP:    push_token(st_pkg::K_LPAREN, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_RP:    push_token(st_pkg::K_RPAREN, off, 16'd1, st_pkg::E_NONE);
            st_pkg::CH_EQ, st_pkg::CH_BANG, st_pkg::CH_GT, st_pkg::CH_LT: begin
                sc_pend  = (c == st_pkg::CH_EQ) ? st_pkg::P_EQ :
                           (c == st_pkg::CH_BANG) ? st_pkg::P_BANG :
                           (c == st_pkg::CH_GT) ? st_pkg::P_GT : st_pkg::P_LT;
                sc_start = off;
                sc_mode  = st_pkg::M_OP;
            end
            st_pkg::CH_QUOTE: begin
                sc_start = off + 16'd1;
                sc_mode  = st_pkg::M_STRING;
            end
            default: begin
                if (dec_digit(c)) begin
                    sc_start = off;
                    sc_mode  = st_pkg::M_INT;
                end else if (alpha(c)) begin
                    sc_start = off;
                    sc_mode  = st_pkg::M_IDENT;
                end else begin
                    halt_on(st_pkg::E_UNKNOWN, off);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] c, logic [15:0] off);
        st_pkg::t_kind one_kind;
        st_pkg::t_kind two_kind;
        case (sc_pend)
            st_pkg::P_EQ: begin
                one_kind = st_pkg::K_EQ;
                two_kind = st_pkg::K_EQEQ;
            end
            st_pkg::P_BANG: begin
                one_kind = st_pkg::K_NEWLINE;
                two_kind = st_pkg::K_NOTEQ;
            end
            st_pkg::P_GT: begin
                one_kind = st_pkg::K_GT;
                two_kind = st_pkg::K_GTEQ;
            end
            default: begin
                one_kind = st_pkg::K_LT;
                two_kind = st_pkg::K_LTEQ;
            end
        endcase
        case (sc_mode)
            st_pkg::M_COMMENT: begin
                if (c == st_pkg::CH_NL) begin
                    sc_mode = st_pkg::M_IDLE;
                    push_token(st_pkg::K_NEWLINE, off, 16'd1, st_pkg::E_NONE);
                end
            end
            st_pkg::M_OP: begin
                sc_mode = st_pkg::M_IDLE;
                if (c == st_pkg::CH_EQ) begin
                    push_token(two_kind, sc_start, 16'd2, st_pkg::E_NONE);
                end else if (sc_pend == st_pkg::P_BANG) begin
                    halt_on(st_pkg::E_BANG, off);
                end else begin
                    push_token(one_kind, sc_start, 16'd1, st_pkg::E_NONE);
                    scan_idle(c, off);
                end
            end
            st_pkg::M_STRING: begin
                if (c == st_pkg::CH_QUOTE) begin
                    close_token(st_pkg::K_STRING, off);
                end else if (c == st_pkg::CH_NL) begin
                    halt_on(st_pkg::E_UNCLOSED, off);
                end
            end
            st_pkg::M_INT: begin
                if (c == st_pkg::CH_DOT) begin
                    sc_mode = st_pkg::M_DOT;
                end else if (!dec_digit(c)) begin
                    close_token(st_pkg::K_NUMBER, off);
                    scan_idle(c, off);
                end
            end
            st_pkg::M_DOT: begin
                if (dec_digit(c)) begin
                    sc_mode = st_pkg::M_FRAC;
                end else begin
                    halt_on(st_pkg::E_FRACTION, off);
                end
            end
            st_pkg::M_FRAC: begin
                if (!dec_digit(c)) begin
                    close_token(st_pkg::K_NUMBER, off);
                    scan_idle(c, off);
                end
            end
            st_pkg::M_IDENT: begin
                if (!(alpha(c) || dec_digit(c) || c == st_pkg::CH_UNDER)) begin
                    close_token(st_pkg::K_IDENT, off);
                    scan_idle(c, off);
                end
            end
            default: begin
                sc_mode = st_pkg::M_IDLE;
                scan_idle(c, off);
            end
        endcase
    endfunction

    // tokens caused by one transfer, left in step_tokens
    function automatic void tokenize_item(st_pkg::t_in item);
        st_pkg::t_out tok;
        step_tokens.delete();
        if (!sc_halted) begin
            if (item.command == CMD_END) begin
                scan_byte(st_pkg::CH_NL, sc_off);
                if (!sc_halted) begin
                    push_token(st_pkg::K_END, sc_off + 16'd1, 16'd0, st_pkg::E_NONE);
                    sc_mode  = st_pkg::M_IDLE;
                    sc_start = '0;
                    sc_off   = '0;
                    sc_pend  = st_pkg::P_EQ;
                end
            end else begin
                scan_byte(item.char_code, sc_off);
                sc_off = sc_off + 16'd1;
            end
            if (step_tokens.size() > 0) begin
                tok = step_tokens.pop_back();
                tok.last_of_run = 1'b1;
                step_tokens.push_back(tok);
            end
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void add_row(logic cmd, logic [7:0] ch, bit typed = 1'b0,
                                    st_pkg::t_kind kind = st_pkg::K_NEWLINE,
                                    int start = 0, int len = 0);
        t_row row;
        row.item.command       = cmd;
        row.item.char_code     = ch;
        row.typed              = typed;
        row.want.token_kind    = kind;
        row.want.start_offset  = start[15:0];
        row.want.text_length   = len[15:0];
        row.want.error_code    = st_pkg::E_NONE;
        row.want.last_of_run   = 1'b1;
        directed_rows.push_back(row);
    endfunction

    function automatic void push_byte(logic [7:0] c);
        st_pkg::t_in item;
        item.command   = CMD_BYTE;
        item.char_code = c;
        source_bytes.push_back(item);
    endfunction

    function automatic void push_end();
        st_pkg::t_in item;
        item.command   = CMD_END;
        item.char_code = 8'($urandom_range(0, 255));
        source_bytes.push_back(item);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 1) begin
            return st_pkg::CH_UA + 8'($urandom_range(0, 25));
        end
        return st_pkg::CH_LA + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return st_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // any byte except the one that ends the construct (and newline)
    function automatic logic [7:0] rand_body(logic [7:0] stop);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == stop || b == st_pkg::CH_NL);
        return b;
    endfunction

    function automatic void gen_token();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            push_byte(rand_letter());
            n = $urandom_range(0, 5);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0:       push_byte(rand_letter());
                    1:       push_byte(rand_digit());
                    default: push_byte(st_pkg::CH_UNDER);
                endcase
            end
            prev_word = 1'b1;
        end else if (pick < 34) begin
            if (prev_word) begin
                push_byte(st_pkg::CH_SP);
            end
            n = $urandom_range(1, 3);
            repeat (n) push_byte(rand_digit());
            if ($urandom_range(0, 1) == 1) begin
                push_byte(st_pkg::CH_DOT);
                n = $urandom_range(1, 2);
                repeat (n) push_byte(rand_digit());
            end
            prev_word = 1'b1;
        end else begin
            prev_word = 1'b0;
            if (pick < 46) begin
                push_byte(st_pkg::CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) push_byte(rand_body(st_pkg::CH_QUOTE));
                push_byte(st_pkg::CH_QUOTE);
            end else if (pick < 70) begin
                case ($urandom_range(0, 12))
                    0:  push_byte(st_pkg::CH_PLUS);
                    1:  push_byte(st_pkg::CH_MINUS);
                    2:  push_byte(st_pkg::CH_STAR);
                    3:  push_byte(st_pkg::CH_SLASH);
                    4:  push_byte(st_pkg::CH_LP);
                    5:  push_byte(st_pkg::CH_RP);
                    6:  push_byte(st_pkg::CH_EQ);
                    7: begin
                        push_byte(st_pkg::CH_EQ);
                        push_byte(st_pkg::CH_EQ);
                    end
                    8: begin
                        push_byte(st_pkg::CH_BANG);
                        push_byte(st_pkg::CH_EQ);
                    end
                    9:  push_byte(st_pkg::CH_GT);
                    10: begin
                        push_byte(st_pkg::CH_GT);
                        push_byte(st_pkg::CH_EQ);
                    end
                    11: push_byte(st_pkg::CH_LT);
                    default: begin
                        push_byte(st_pkg::CH_LT);
                        push_byte(st_pkg::CH_EQ);
                    end
                endcase
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0:       push_byte(st_pkg::CH_SP);
                    1:       push_byte(st_pkg::CH_TAB);
                    default: push_byte(st_pkg::CH_CR);
                endcase
            end else if (pick < 88) begin
                push_byte(st_pkg::CH_NL);
            end else if (pick < 94) begin
                push_byte(st_pkg::CH_HASH);
                n = $urandom_range(0, 4);
                repeat (n) push_byte(rand_body(st_pkg::CH_NL));
                push_byte(st_pkg::CH_NL);
            end else begin
                push_end();
            end
        end
    endfunction

    // one broken construct, then input the halted block must ignore
    function automatic void gen_error_tail();
        st_pkg::t_err pick;
        push_byte(st_pkg::CH_SP);
        pick = st_pkg::t_err'($urandom_range(1, 4));
        case (pick)
            st_pkg::E_BANG: begin
                push_byte(st_pkg::CH_BANG);
                if ($urandom_range(0, 1) == 1) push_end();
                else push_byte(rand_letter());
            end
            st_pkg::E_UNCLOSED: begin
                push_byte(st_pkg::CH_QUOTE);
                push_byte(rand_body(st_pkg::CH_QUOTE));
                if ($urandom_range(0, 1) == 1) push_end();
                else push_byte(st_pkg::CH_NL);
            end
            st_pkg::E_FRACTION: begin
                push_byte(rand_digit());
                push_byte(st_pkg::CH_DOT);
                if ($urandom_range(0, 1) == 1) push_end();
                else push_byte(rand_letter());
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       push_byte(st_pkg::CH_DOT);
                    1:       push_byte(st_pkg::CH_UNDER);
                    2:       push_byte(8'h2C);
                    3:       push_byte(8'h7B);
                    4:       push_byte(8'h00);
                    default: push_byte(8'($urandom_range(128, 255)));
                endcase
            end
        endcase
        repeat (6) begin
            if ($urandom_range(0, 3) == 0) push_end();
            else push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // ---------------- input side ----------------

    task automatic offer(input st_pkg::t_in item);
        if (!calm && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(posedge clk);
        end while (!in_ready);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send(input st_pkg::t_in item, input bit typed, input st_pkg::t_out want);
        offer(item);
        tokenize_item(item);
        if (typed) begin
            expected_tokens.push_back(want);
        end else begin
            foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        end
    endtask

    initial begin
        st_pkg::t_out none;
        none       = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        rst_n      = 1'b0;
        n_sent     = 0;
        mismatches = 0;
        prev_word  = 1'b0;
        sc_mode    = st_pkg::M_IDLE;
        sc_start   = '0;
        sc_off     = '0;
        sc_pend    = st_pkg::P_EQ;
        sc_halted  = 1'b0;

        add_row(CMD_BYTE, st_pkg::CH_NL, 1'b1, st_pkg::K_NEWLINE, 0, 1);
        add_row(CMD_BYTE, st_pkg::CH_PLUS, 1'b1, st_pkg::K_PLUS, 1, 1);
        add_row(CMD_BYTE, st_pkg::CH_LT);
        add_row(CMD_BYTE, st_pkg::CH_LP);
        add_row(CMD_BYTE, st_pkg::CH_EQ);
        add_row(CMD_BYTE, st_pkg::CH_STAR);
        add_row(CMD_BYTE, st_pkg::CH_GT);
        add_row(CMD_BYTE, st_pkg::CH_MINUS);
        add_row(CMD_BYTE, st_pkg::CH_BANG);
        add_row(CMD_BYTE, st_pkg::CH_EQ, 1'b1, st_pkg::K_NOTEQ, 8, 2);
        add_row(CMD_BYTE, st_pkg::CH_GT);
        add_row(CMD_BYTE, st_pkg::CH_EQ, 1'b1, st_pkg::K_GTEQ, 10, 2);
        add_row(CMD_BYTE, st_pkg::CH_LT);
        add_row(CMD_BYTE, st_pkg::CH_EQ, 1'b1, st_pkg::K_LTEQ, 12, 2);
        add_row(CMD_BYTE, st_pkg::CH_EQ);
        add_row(CMD_BYTE, st_pkg::CH_EQ, 1'b1, st_pkg::K_EQEQ, 14, 2);
        add_row(CMD_BYTE, st_pkg::CH_QUOTE);
        add_row(CMD_BYTE, 8'hFF);
        add_row(CMD_BYTE, 8'h00);
        add_row(CMD_BYTE, st_pkg::CH_QUOTE, 1'b1, st_pkg::K_STRING, 17, 2);
        add_row(CMD_BYTE, st_pkg::CH_9);
        add_row(CMD_BYTE, st_pkg::CH_DOT);
        add_row(CMD_BYTE, st_pkg::CH_0);
        add_row(CMD_BYTE, st_pkg::CH_LZ);
        add_row(CMD_BYTE, st_pkg::CH_UNDER);
        add_row(CMD_BYTE, st_pkg::CH_SLASH);
        add_row(CMD_BYTE, st_pkg::CH_TAB);
        add_row(CMD_BYTE, st_pkg::CH_RP, 1'b1, st_pkg::K_RPAREN, 27, 1);
        add_row(CMD_BYTE, st_pkg::CH_UA);
        add_row(CMD_END, 8'hA5);

        while (source_bytes.size() < 170) gen_token();
        gen_error_tail();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r]) begin
            send(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end
        foreach (source_bytes[i]) begin
            send(source_bytes[i], 1'b0, none);
        end
        in_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ---------------- output side ----------------

    initial begin
        hold_off = 1'b0;
        wait (n_sent >= 140);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 7);
        end
    end

    function automatic void flag_token(string what, st_pkg::t_out want, st_pkg::t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%s: expected kind=%0d start=%0d len=%0d err=%0d last=%0b, ",
                   what, want.token_kind, want.start_offset, want.text_length,
                   want.error_code, want.last_of_run);
            $display("got kind=%0d start=%0d len=%0d err=%0d last=%0b",
                     got.token_kind, got.start_offset, got.text_length,
                     got.error_code, got.last_of_run);
        end
    endfunction

    initial cycle_count = 0;

    always @(posedge clk) begin
        st_pkg::t_out want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                flag_token("unexpected token", '0, out_data);
            end else begin
                want = expected_tokens.pop_front();
                if (out_data.token_kind   !== want.token_kind   ||
                    out_data.start_offset !== want.start_offset ||
                    out_data.text_length  !== want.text_length  ||
                    out_data.error_code   !== want.error_code   ||
                    out_data.last_of_run  !== want.last_of_run) begin
                    flag_token("token mismatch", want, out_data);
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout with %0d tokens outstanding", expected_tokens.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/st_pkg.sv
hw/rtl/st_front.sv
hw/rtl/st_queue.sv
hw/rtl/st_back.sv
hw/rtl/source_tokenizer.sv
hw/rtl/st_checker.sv
tb/sv/tb_source_tokenizer.sv
